// ===== sv/wmb_pkg.sv =====
package wmb_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int VALUE_BITS_DEF = 32;

    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_W     = 34;
    // fold stage, one stage per step, round and clamp stage
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;

    localparam int TRIG_W = 18;
    localparam int ROT_W  = 21;

    localparam logic [1:0]  ROW_LAST = 2'd3;
    localparam logic [16:0] ONE_Q16  = 17'd65536;

    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef logic signed [ROT_W-1:0]  rot_t;

endpackage

// ===== sv/world_matrix_builder.sv =====
// output: row 0 of a matrix first, then one row per cycle while m_tready is high
// throughput: set by the four-row serializer, which reloads as its last row is taken; the
// 39-stage pipeline before it takes items back to back until the serializer backs it up
// reset: synchronous active-low aresetn clears all valid bits and the serializer; no
// clearing pass, the block accepts requests in the first cycle after reset
module world_matrix_builder #(
    parameter int ANGLE_BITS = wmb_pkg::ANGLE_BITS_DEF,
    parameter int VALUE_BITS = wmb_pkg::VALUE_BITS_DEF,
    localparam int IN_W  = ((6 * VALUE_BITS + 3 * ANGLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((3 * VALUE_BITS + 19 + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // scale_x, scale_y, scale_z, angle_x, angle_y, angle_z, move_x, move_y, move_z
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // row_index, col0, col1, col2, col3
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast
);
    import wmb_pkg::*;

    localparam int VB     = VALUE_BITS;
    localparam int AB     = ANGLE_BITS;
    localparam int SIDE_W = 6 * VB;
    localparam int A_OFF  = 3 * VB;
    localparam int M_OFF  = 3 * VB + 3 * AB;

    logic en;

    // scales and moves ride alongside the cordic lanes
    logic [SIDE_W-1:0] side_in;
    logic [SIDE_W-1:0] dly_reg [0:CORDIC_LAT-1];
    logic              dv_reg  [0:CORDIC_LAT-1];

    assign side_in = {s_tdata[M_OFF +: 3*VB], s_tdata[0 +: 3*VB]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < CORDIC_LAT; k++) begin
                dv_reg[k] <= 1'b0;
            end
        end else if (en) begin
            dv_reg[0] <= s_tvalid;
            for (int k = 1; k < CORDIC_LAT; k++) begin
                dv_reg[k] <= dv_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dly_reg[0] <= side_in;
            for (int k = 1; k < CORDIC_LAT; k++) begin
                dly_reg[k] <= dly_reg[k-1];
            end
        end
    end

    trig_t sx, cx, sy, cy, sz, cz;

    wmb_cordic #(.ANGLE_BITS(AB)) u_cordic_x (
        .aclk (aclk),
        .en   (en),
        .angle(s_tdata[A_OFF +: AB]),
        .sin_o(sx),
        .cos_o(cx)
    );

    wmb_cordic #(.ANGLE_BITS(AB)) u_cordic_y (
        .aclk (aclk),
        .en   (en),
        .angle(s_tdata[A_OFF + AB +: AB]),
        .sin_o(sy),
        .cos_o(cy)
    );

    wmb_cordic #(.ANGLE_BITS(AB)) u_cordic_z (
        .aclk (aclk),
        .en   (en),
        .angle(s_tdata[A_OFF + 2*AB +: AB]),
        .sin_o(sz),
        .cos_o(cz)
    );

    logic              rot_valid;
    rot_t              rot [3][3];
    logic [SIDE_W-1:0] rot_side;

    wmb_rotate #(.SIDE_W(SIDE_W)) u_rotate (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (dv_reg[CORDIC_LAT-1]),
        .sin_x    (sx),
        .cos_x    (cx),
        .sin_y    (sy),
        .cos_y    (cy),
        .sin_z    (sz),
        .cos_z    (cz),
        .side_i   (dly_reg[CORDIC_LAT-1]),
        .out_valid(rot_valid),
        .rot_o    (rot),
        .side_o   (rot_side)
    );

    logic [VB-1:0] scl [3];
    logic [VB-1:0] mov [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            scl[i] = rot_side[i*VB +: VB];
            mov[i] = rot_side[(3+i)*VB +: VB];
        end
    end

    logic          sc_valid;
    logic [VB-1:0] sc_col [3][3];
    logic [VB-1:0] sc_move [3];

    wmb_scale #(.VALUE_BITS(VB)) u_scale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (rot_valid),
        .rot_i    (rot),
        .scale_i  (scl),
        .move_i   (mov),
        .out_valid(sc_valid),
        .col_o    (sc_col),
        .move_o   (sc_move)
    );

    // row serializer: holds one matrix, rows 0 to 2 scaled rotation, row 3 translation
    logic [VB-1:0] mat_reg [4][3];
    logic          full_reg;
    logic [1:0]    row_reg;
    logic          take;

    assign take = !full_reg || (m_tready && row_reg == ROW_LAST);
    assign en   = !sc_valid || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
            row_reg  <= '0;
        end else if (sc_valid && take) begin
            full_reg <= 1'b1;
            row_reg  <= '0;
        end else if (full_reg && m_tready) begin
            row_reg <= row_reg + 2'd1;
            if (row_reg == ROW_LAST) begin
                full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sc_valid && take) begin
            for (int i = 0; i < 3; i++) begin
                mat_reg[i]    <= sc_col[i];
                mat_reg[3][i] <= sc_move[i];
            end
        end
    end

    logic [16:0] col3;
    assign col3 = (row_reg == ROW_LAST) ? ONE_Q16 : '0;

    assign s_tready = en;
    assign m_tvalid = full_reg;
    assign m_tlast  = (row_reg == ROW_LAST);
    assign m_tdata  = OUT_W'({col3, mat_reg[row_reg][2], mat_reg[row_reg][1],
                              mat_reg[row_reg][0], row_reg});

endmodule

// ===== sv/wmb_cordic.sv =====
module wmb_cordic #(
    parameter int ANGLE_BITS = wmb_pkg::ANGLE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [ANGLE_BITS-1:0] angle,
    output wmb_pkg::trig_t        sin_o,
    output wmb_pkg::trig_t        cos_o
);
    import wmb_pkg::*;

    localparam int SH = 32 - ANGLE_BITS;
    localparam logic signed [CORDIC_W-1:0] QUARTER = 34'sh040000000;
    localparam logic signed [CORDIC_W-1:0] HALF    = 34'sh080000000;
    localparam logic signed [CORDIC_W-1:0] GAIN    = 34'sd652032874;
    localparam logic signed [CORDIC_W-1:0] LIM     = 34'sd65536;

    function automatic logic [31:0] atan_turns(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            default: v = '0;
        endcase
        return v;
    endfunction

    logic signed [CORDIC_W-1:0] a_reg [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] y_reg [0:CORDIC_STEPS];
    logic                       flip_reg [0:CORDIC_STEPS];

    logic signed [CORDIC_W-1:0] a_in;
    logic signed [CORDIC_W-1:0] a_fold;
    logic                       flip_in;

    always_comb begin
        a_in    = CORDIC_W'($signed(angle)) <<< SH;
        flip_in = (a_in > QUARTER) || (a_in < -QUARTER);
        if (!flip_in) begin
            a_fold = a_in;
        end else if (a_in < 0) begin
            a_fold = a_in + HALF;
        end else begin
            a_fold = a_in - HALF;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg[0]    <= a_fold;
            x_reg[0]    <= GAIN;
            y_reg[0]    <= '0;
            flip_reg[0] <= flip_in;
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        localparam logic signed [CORDIC_W-1:0] ATN = CORDIC_W'(atan_turns(k));
        always_ff @(posedge aclk) begin
            if (en) begin
                if (a_reg[k] >= 0) begin
                    x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> k);
                    a_reg[k+1] <= a_reg[k] - ATN;
                end else begin
                    x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> k);
                    a_reg[k+1] <= a_reg[k] + ATN;
                end
                flip_reg[k+1] <= flip_reg[k];
            end
        end
    end

    logic signed [CORDIC_W-1:0] tx, ty, cx, cy;
    trig_t                      cos_reg, sin_reg;

    always_comb begin
        tx = (x_reg[CORDIC_STEPS] + 34'sd8192) >>> 14;
        ty = (y_reg[CORDIC_STEPS] + 34'sd8192) >>> 14;
        cx = (tx > LIM) ? LIM : ((tx < -LIM) ? -LIM : tx);
        cy = (ty > LIM) ? LIM : ((ty < -LIM) ? -LIM : ty);
        if (flip_reg[CORDIC_STEPS]) begin
            cx = -cx;
            cy = -cy;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= cx[TRIG_W-1:0];
            sin_reg <= cy[TRIG_W-1:0];
        end
    end

    assign sin_o = sin_reg;
    assign cos_o = cos_reg;

endmodule

// ===== sv/wmb_rotate.sv =====
module wmb_rotate #(
    parameter int SIDE_W = 6 * wmb_pkg::VALUE_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  wmb_pkg::trig_t     sin_x,
    input  wmb_pkg::trig_t     cos_x,
    input  wmb_pkg::trig_t     sin_y,
    input  wmb_pkg::trig_t     cos_y,
    input  wmb_pkg::trig_t     sin_z,
    input  wmb_pkg::trig_t     cos_z,
    input  logic [SIDE_W-1:0]  side_i,
    output logic               out_valid,
    output wmb_pkg::rot_t      rot_o [3][3],
    output logic [SIDE_W-1:0]  side_o
);
    import wmb_pkg::*;

    localparam int PP_W = 2 * TRIG_W;
    localparam int Q_W  = ROT_W + TRIG_W;

    function automatic rot_t rnd_q16(input logic signed [47:0] v);
        logic signed [47:0] t;
        t = (v + 48'sd32768) >>> 16;
        return t[ROT_W-1:0];
    endfunction

    logic [3:0] v_reg;
    logic [SIDE_W-1:0] side1_reg, side2_reg, side3_reg, side4_reg;

    // stage 1: products for Rz * Ry
    logic signed [PP_W-1:0] pp00_reg, pp02_reg, pp10_reg, pp12_reg;
    trig_t sz1_reg, cz1_reg, sy1_reg, cy1_reg, sx1_reg, cx1_reg;
    // stage 2: P = Rz * Ry
    rot_t  p_reg [3][3];
    trig_t sx2_reg, cx2_reg;
    // stage 3: products for P * Rx
    logic signed [Q_W-1:0] qa_reg [3], qb_reg [3], qc_reg [3], qd_reg [3];
    rot_t  p0_reg [3];
    // stage 4: R
    rot_t  r_reg [3][3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pp00_reg  <= cos_z * cos_y;
            pp02_reg  <= cos_z * (-sin_y);
            pp10_reg  <= (-sin_z) * cos_y;
            pp12_reg  <= sin_z * sin_y;
            sz1_reg   <= sin_z;
            cz1_reg   <= cos_z;
            sy1_reg   <= sin_y;
            cy1_reg   <= cos_y;
            sx1_reg   <= sin_x;
            cx1_reg   <= cos_x;
            side1_reg <= side_i;

            p_reg[0][0] <= rnd_q16(48'(pp00_reg));
            p_reg[0][1] <= ROT_W'(sz1_reg);
            p_reg[0][2] <= rnd_q16(48'(pp02_reg));
            p_reg[1][0] <= rnd_q16(48'(pp10_reg));
            p_reg[1][1] <= ROT_W'(cz1_reg);
            p_reg[1][2] <= rnd_q16(48'(pp12_reg));
            p_reg[2][0] <= ROT_W'(sy1_reg);
            p_reg[2][1] <= '0;
            p_reg[2][2] <= ROT_W'(cy1_reg);
            sx2_reg     <= sx1_reg;
            cx2_reg     <= cx1_reg;
            side2_reg   <= side1_reg;

            for (int i = 0; i < 3; i++) begin
                qa_reg[i] <= p_reg[i][1] * cx2_reg;
                qb_reg[i] <= p_reg[i][2] * sx2_reg;
                qc_reg[i] <= p_reg[i][1] * sx2_reg;
                qd_reg[i] <= p_reg[i][2] * cx2_reg;
                p0_reg[i] <= p_reg[i][0];
            end
            side3_reg <= side2_reg;

            for (int i = 0; i < 3; i++) begin
                r_reg[i][0] <= p0_reg[i];
                r_reg[i][1] <= rnd_q16(48'(qa_reg[i]) - 48'(qb_reg[i]));
                r_reg[i][2] <= rnd_q16(48'(qc_reg[i]) + 48'(qd_reg[i]));
            end
            side4_reg <= side3_reg;
        end
    end

    assign out_valid = v_reg[3];
    assign rot_o     = r_reg;
    assign side_o    = side4_reg;

endmodule

// ===== sv/wmb_scale.sv =====
module wmb_scale #(
    parameter int VALUE_BITS = wmb_pkg::VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  wmb_pkg::rot_t         rot_i [3][3],
    input  logic [VALUE_BITS-1:0] scale_i [3],
    input  logic [VALUE_BITS-1:0] move_i [3],
    output logic                  out_valid,
    output logic [VALUE_BITS-1:0] col_o [3][3],
    output logic [VALUE_BITS-1:0] move_o [3]
);
    import wmb_pkg::*;

    localparam int PR_W = VALUE_BITS + ROT_W;
    localparam logic [PR_W-1:0]       LIM   = PR_W'(1) << (VALUE_BITS - 1);
    localparam logic [PR_W-1:0]       HALF  = PR_W'(32768);
    localparam logic [VALUE_BITS-1:0] MIN_V = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [VALUE_BITS-1:0] MAX_V = ~MIN_V;

    logic [2:0] v_reg;

    logic [VALUE_BITS-1:0] ms_reg [3];
    logic [ROT_W-1:0]      mr_reg [3][3];
    logic                  neg0_reg [3][3];
    logic [VALUE_BITS-1:0] mv0_reg [3];

    logic [PR_W-1:0]       prod_reg [3][3];
    logic                  neg1_reg [3][3];
    logic [VALUE_BITS-1:0] mv1_reg [3];

    logic [VALUE_BITS-1:0] col_reg [3][3];
    logic [VALUE_BITS-1:0] mv2_reg [3];

    logic [VALUE_BITS-1:0] col_next [3][3];
    logic [PR_W-1:0]       rp [3][3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                rp[i][j] = (prod_reg[i][j] + HALF) >> 16;
                if (neg1_reg[i][j]) begin
                    col_next[i][j] = (rp[i][j] >= LIM) ? MIN_V
                                                       : (~rp[i][j][VALUE_BITS-1:0] + 1'b1);
                end else begin
                    col_next[i][j] = (rp[i][j] >= LIM) ? MAX_V : rp[i][j][VALUE_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                ms_reg[i]  <= scale_i[i][VALUE_BITS-1] ? (~scale_i[i] + 1'b1) : scale_i[i];
                mv0_reg[i] <= move_i[i];
                for (int j = 0; j < 3; j++) begin
                    mr_reg[i][j]   <= rot_i[i][j][ROT_W-1] ? (~rot_i[i][j] + 1'b1) : rot_i[i][j];
                    neg0_reg[i][j] <= scale_i[i][VALUE_BITS-1] ^ rot_i[i][j][ROT_W-1];
                end
            end

            for (int i = 0; i < 3; i++) begin
                mv1_reg[i] <= mv0_reg[i];
                for (int j = 0; j < 3; j++) begin
                    prod_reg[i][j] <= PR_W'(ms_reg[i]) * PR_W'(mr_reg[i][j]);
                    neg1_reg[i][j] <= neg0_reg[i][j];
                end
            end

            col_reg <= col_next;
            mv2_reg <= mv1_reg;
        end
    end

    assign out_valid = v_reg[2];
    assign col_o     = col_reg;
    assign move_o    = mv2_reg;

endmodule
